>>> sv/modexp_pkg.sv
// Shared constants for the modular exponentiation block.
`default_nettype none
package modexp_pkg;
  // Default operand width in bits (legal range 8 to 64).
  localparam int unsigned WORD_BITS_DEFAULT = 32;
endpackage
`default_nettype wire

>>> sv/modular_exponentiation.sv
// Modular exponentiation top level: sequencer and shared shift-add modular multiplier.
`default_nettype none
// Computes base_value ** exponent mod modulus, one word at a time.
// A word is taken when start is high and busy is low. Its result shows on
// result for exactly one cycle, marked by done. The receiver cannot stall,
// so done is never held back. busy is low again in the same cycle that done
// is high, so a new word can be started then.
// Sequence: a zero modulus gives 0, and a zero exponent gives 1. Either result
// comes in the cycle after start. Otherwise the base is first reduced, and
// a pick state then chooses the next operation. Then each set exponent bit
// takes a modular multiply, and every bit below the top set bit takes a
// square. A pick state follows each of these. The square is skipped after
// the top set bit. The final pick state registers the result and done.
// Every modular multiply runs on one shared unit. That unit handles one
// multiplier bit per cycle: it doubles the accumulator and conditionally
// adds, and reduces by the modulus after each of those two steps.
// No state is kept from one word to the next. Reset clears only the
// sequencer and done.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [WORD_BITS-1:0] base_value,
  input  wire logic [WORD_BITS-1:0] exponent,
  input  wire logic [WORD_BITS-1:0] modulus,
  output logic                      done,
  output logic [WORD_BITS-1:0]      result
);

  localparam int unsigned CW = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONE  = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] ZERO = '0;
  localparam logic [CW-1:0] LAST_BIT = CW'(WORD_BITS - 1);

  // IDLE: waiting; REDUCE: base mod m; PICK: choose next op;
  // MUL: acc * b; SQR: b * b.
  typedef enum logic [2:0] {
    IDLE,
    REDUCE,
    PICK,
    MUL,
    SQR
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] m;     // modulus
  logic [WORD_BITS-1:0] e;     // exponent bits still to handle
  logic [WORD_BITS-1:0] b;     // running power of the base
  logic [WORD_BITS-1:0] acc;   // running result

  // Shared multiplier unit: uacc = (ua * ub) mod m, MSB of ub first.
  logic [WORD_BITS-1:0] ua;
  logic [WORD_BITS-1:0] ub;
  logic [WORD_BITS-1:0] uacc;
  logic [CW-1:0]        cnt;

  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS-1:0] d1;
  logic [WORD_BITS-1:0] d2;
  logic [WORD_BITS-1:0] step_next;
  logic [WORD_BITS-1:0] acc_op;  // acc reduced: only 1 mod 1 differs

  always_comb begin
    dbl = {uacc, 1'b0};
    d1  = (dbl >= {1'b0, m}) ? WORD_BITS'(dbl - {1'b0, m}) : dbl[WORD_BITS-1:0];
    sum = {1'b0, d1} + {1'b0, ua};
    d2  = (sum >= {1'b0, m}) ? WORD_BITS'(sum - {1'b0, m}) : sum[WORD_BITS-1:0];
    step_next = ub[WORD_BITS-1] ? d2 : d1;
    acc_op    = (m == ONE) ? ZERO : acc;
  end

  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            m   <= modulus;
            e   <= exponent;
            acc <= ONE;
            if (modulus == ZERO) begin
              result <= ZERO;
              done   <= 1'b1;
            end else if (exponent == ZERO) begin
              result <= ONE;
              done   <= 1'b1;
            end else begin
              // base mod m == (1 * base) mod m, with 1 itself reduced
              ua    <= (modulus == ONE) ? ZERO : ONE;
              ub    <= base_value;
              uacc  <= ZERO;
              cnt   <= LAST_BIT;
              state <= REDUCE;
            end
          end
        end
        PICK: begin
          if (e == ZERO) begin
            result <= acc;
            done   <= 1'b1;
            state  <= IDLE;
          end else if (e[0]) begin
            ua    <= acc_op;
            ub    <= b;
            uacc  <= ZERO;
            cnt   <= LAST_BIT;
            state <= MUL;
          end else begin
            ua    <= b;
            ub    <= b;
            uacc  <= ZERO;
            cnt   <= LAST_BIT;
            state <= SQR;
          end
        end
        REDUCE, MUL, SQR: begin
          uacc <= step_next;
          ub   <= {ub[WORD_BITS-2:0], 1'b0};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= PICK;
            unique case (state)
              REDUCE: b <= step_next;
              MUL: begin
                acc  <= step_next;
                e[0] <= 1'b0;
              end
              default: begin
                b <= step_next;
                e <= e >> 1;
              end
            endcase
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/modexp_checker.sv
// Port-level checker for the modular exponentiation block, with its bind.
`default_nettype none
module modexp_checker
  import modexp_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic [WORD_BITS-1:0] exponent,
  input wire logic [WORD_BITS-1:0] modulus,
  input wire logic                 done,
  input wire logic [WORD_BITS-1:0] result
);

  // A result word frees the block in the same cycle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // An accepted word either starts work or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word dropped");

  // Work ends only with a result.
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without result");

  // Zero exponent gives one, for any nonzero modulus.
  a_exp_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && exponent == '0 && modulus != '0)
      |=> (done && result == WORD_BITS'(1)))
    else $error("zero exponent result wrong");

  // Zero modulus gives zero.
  a_mod_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && modulus == '0) |=> (done && result == '0))
    else $error("zero modulus result wrong");

endmodule

bind modular_exponentiation modexp_checker #(.WORD_BITS(WORD_BITS)) u_modexp_checker (.*);
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for modular_exponentiation: directed and random words.
`timescale 1ns / 100ps
module testbench;
  import modexp_pkg::*;

  localparam int unsigned WORD_BITS = WORD_BITS_DEFAULT;
  // The wait for outstanding results covers the worst word, so this is only
  // slack to catch a stray result.
  localparam int unsigned DRAIN_CYCLES = 3 * WORD_BITS + 8;
  localparam int unsigned RANDOM_WORDS = 250;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [2*WORD_BITS-1:0] wide_t;

  // One command word: all three operands travel together.
  typedef struct packed {
    word_t base_value;
    word_t exponent;
    word_t modulus;
  } modexp_word_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  word_t base_value = '0;
  word_t exponent = '0;
  word_t modulus = '1;
  logic  done;
  word_t result;

  modexp_word_t pending_words[$];     // words not yet offered to the block
  word_t        expected_residues[$]; // results of accepted words, oldest first
  modexp_word_t offered_word;         // word currently on the input ports
  int unsigned  idle_left = 0;        // start-low cycles before the next offer
  int unsigned  burst_left = 0;       // offers left in a back-to-back run
  int unsigned  failures = 0;

  modular_exponentiation #(
    .WORD_BITS(WORD_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .base_value(base_value),
    .exponent(exponent),
    .modulus(modulus),
    .done(done),
    .result(result)
  );

  always #10 clk = ~clk;

  // Right-to-left square-and-multiply at double width, so products never wrap.
  // A zero exponent leaves the running product at 1, even for modulus 1.
  function automatic word_t power_mod(input modexp_word_t w);
    wide_t m;
    wide_t sq;
    wide_t acc;
    word_t e;
    if (w.modulus == '0) return '0;
    m   = wide_t'(w.modulus);
    sq  = wide_t'(w.base_value) % m;
    acc = wide_t'(1);
    e   = w.exponent;
    while (e != '0) begin
      if (e[0]) acc = ((acc % m) * sq) % m;
      sq = (sq * sq) % m;
      e  = e >> 1;
    end
    return acc[WORD_BITS-1:0];
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with no gaps.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(8, 30);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  task automatic queue_word(input word_t b, input word_t e, input word_t m);
    modexp_word_t w;
    w.base_value = b;
    w.exponent   = e;
    w.modulus    = m;
    pending_words.push_back(w);
  endtask

  // Exponent lengths lean short to keep the run brisk; a tenth get 25 bits up to full width.
  function automatic word_t random_exponent();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 70) len = $urandom_range(1, 12);
    else if (r < 90) len = $urandom_range(13, 24);
    else len = $urandom_range(25, WORD_BITS);
    return word_t'($urandom) >> (WORD_BITS - len);
  endfunction

  function automatic word_t random_modulus();
    int unsigned r;
    word_t m;
    r = $urandom_range(0, 99);
    if (r < 30) return word_t'($urandom_range(1, 300));
    if (r < 50) return '1 - word_t'($urandom_range(0, 1000));
    m = word_t'($urandom);
    return (m == '0) ? word_t'(1) : m;
  endfunction

  function automatic word_t random_base();
    if ($urandom_range(0, 99) < 15) return word_t'($urandom_range(0, 5));
    return word_t'($urandom);
  endfunction

  // Driver: a word is taken on an edge with start high and busy low. Once
  // taken (or while idle) the next word is offered, possibly after a gap.
  // start stays high across back-to-back words, so it gets one update per edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_residues.push_back(power_mod(offered_word));
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start      <= 1'b0;
          // operands are don't-care while start is low; wiggle them
          base_value <= word_t'($urandom);
          exponent   <= word_t'($urandom);
          modulus    <= word_t'($urandom);
        end else if (pending_words.size() > 0) begin
          offered_word = pending_words.pop_front();
          base_value <= offered_word.base_value;
          exponent   <= offered_word.exponent;
          modulus    <= offered_word.modulus;
          start      <= 1'b1;
          idle_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: done marks a result for exactly one cycle; the oldest expectation
  // must match it.
  always @(posedge clk) begin
    word_t want;
    if (!rst && done) begin
      if (expected_residues.size() == 0) begin
        $error("result with no word outstanding: actual %h", result);
        failures++;
      end else begin
        want = expected_residues.pop_front();
        if (result !== want) begin
          $error("result mismatch: expected %h, actual %h", want, result);
          failures++;
        end
      end
    end
  end

  initial begin
    // Directed words: zero exponent, unit modulus, reduction of the base,
    // operand extremes, and a few small results known by hand.
    queue_word(32'd5, 32'd0, 32'd1);                       // zero exponent, modulus 1
    queue_word('1, 32'd0, '1);                             // zero exponent, big operands
    queue_word(32'd0, 32'd0, 32'd7);                       // zero to the zero
    queue_word(32'd0, 32'd5, 32'd7);                       // zero base
    queue_word('1, '1, 32'd1);                             // modulus 1 collapses to 0
    queue_word('1, 32'd1, 32'd2);                          // exponent 1, tiny modulus
    queue_word(32'd13, 32'd1, 32'd13);                     // base equals modulus
    queue_word(32'd26, 32'd3, 32'd13);                     // base a multiple of modulus
    queue_word(32'd123456789, 32'd1, 32'd1000);            // exponent 1 is base mod m
    queue_word(32'd4, 32'd13, 32'd497);
    queue_word(32'd2, 32'd10, 32'd1000);
    queue_word(32'd2, '1, 32'd3);
    queue_word(32'd3, 32'h8000_0000, 32'd1_000_003);       // only the top exponent bit
    queue_word('1 - 32'd1, 32'd2, '1);                     // (m-1)^2 = 1 at top modulus
    queue_word('1, '1, '1);                                // all ones
    queue_word('1, '1, 32'hFFFF_FFFB);
    queue_word(32'h7FFF_FFFF, '1, 32'h8000_0000);
    queue_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE);
    queue_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001);
    queue_word(32'd1, '1, 32'd97);
    for (int i = 0; i < RANDOM_WORDS; i++)
      queue_word(random_base(), random_exponent(), random_modulus());

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || start || expected_residues.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung run: the slowest legal run of about 270 words ends well inside it.
  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
